### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the date adder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/cdad_pkg.sv
// ---------------------------------------------------------------------------
// cdad_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ---------------------------------------------------------------------------
package cdad_pkg;

   // Calendar constants.
   localparam int MONTHS     = 12;
   localparam int DAY_MAX    = 31;
   localparam int YEAR_BASE  = 1900;
   localparam int YEAR_CYCLE = 400;
   localparam int CENTURY    = 100;

   // Program counter of the control sequencer.
   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_REDUCE = 3'd1;
   localparam step_type STEP_SCAN   = 3'd2;
   localparam step_type STEP_SUM    = 3'd3;
   localparam step_type STEP_WALK   = 3'd4;
   localparam step_type STEP_EMIT   = 3'd5;

   // Datapath operation selected by a control word.
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_LOAD   = 3'd1,
      OP_REDUCE = 3'd2,
      OP_SCAN   = 3'd3,
      OP_SUM    = 3'd4,
      OP_WALK   = 3'd5,
      OP_EMIT   = 3'd6
   } op_type;

   // Jump condition selected by a control word.
   typedef enum logic [2:0] {
      C_NEVER     = 3'd0,
      C_ALWAYS    = 3'd1,
      C_IDLE      = 3'd2,
      C_YEAR_HIGH = 3'd3,
      C_SCAN_MORE = 3'd4,
      C_WALK_MORE = 3'd5
   } cond_type;

   // One microcode word: operation, jump condition and jump target.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Status flags from the datapath to the sequencer.
   typedef struct packed {
      logic start;
      logic year_high;
      logic scan_more;
      logic walk_more;
   } flags_type;

   // Leap test on the year reduced modulo 400.
   function automatic logic is_leap(input logic [8:0] ymod);
      is_leap = (ymod[1:0] == 2'd0) &&
                (ymod != 9'(CENTURY)) &&
                (ymod != 9'(2 * CENTURY)) &&
                (ymod != 9'(3 * CENTURY));
   endfunction

   // Length of a month from 1 to 12; any other code reads as January.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'(DAY_MAX);
      endcase
      month_len = len;
   endfunction

endpackage

### sv/cdad_seq.sv
// ---------------------------------------------------------------------------
// cdad_seq
// Microcode sequencer: a step counter walks a read-only program and issues
// one control word per cycle, with conditional jumps on datapath flags.
// ---------------------------------------------------------------------------
module cdad_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  cdad_pkg::flags_type      flags,
   output cdad_pkg::ctrl_word_type  ctrl,
   output logic                     busy
);
   import cdad_pkg::*;

   step_type      pc_ff;
   step_type      pc_in;
   ctrl_word_type word;
   logic          take_jump;

   // Control program.
   always_comb begin
      unique case (pc_ff)
         STEP_WAIT:   word = '{op: OP_LOAD,   cond: C_IDLE,      target: STEP_WAIT};
         STEP_REDUCE: word = '{op: OP_REDUCE, cond: C_YEAR_HIGH, target: STEP_REDUCE};
         STEP_SCAN:   word = '{op: OP_SCAN,   cond: C_SCAN_MORE, target: STEP_SCAN};
         STEP_SUM:    word = '{op: OP_SUM,    cond: C_NEVER,     target: STEP_SUM};
         STEP_WALK:   word = '{op: OP_WALK,   cond: C_WALK_MORE, target: STEP_WALK};
         STEP_EMIT:   word = '{op: OP_EMIT,   cond: C_ALWAYS,    target: STEP_WAIT};
         default:     word = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_WAIT};
      endcase
   end

   // Jump condition decode.
   always_comb begin
      unique case (word.cond)
         C_NEVER:     take_jump = 1'b0;
         C_ALWAYS:    take_jump = 1'b1;
         C_IDLE:      take_jump = !flags.start;
         C_YEAR_HIGH: take_jump = flags.year_high;
         C_SCAN_MORE: take_jump = flags.scan_more;
         C_WALK_MORE: take_jump = flags.walk_more;
         default:     take_jump = 1'b1;
      endcase
   end

   assign pc_in = take_jump ? word.target : pc_ff + 3'd1;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = word;
   assign busy = (pc_ff != STEP_WAIT);

endmodule

### sv/calendar_date_add_days.sv
// ---------------------------------------------------------------------------
// calendar_date_add_days
// Normalizes a Gregorian date, reports leap year, month length, day of year
// and days left, and adds a day count by walking month by month.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                          Handshake
//   -------   ----------------------------   ---------------------------
//   request   req_month_raw .. req_days_to_add  start high, busy low
//   response  rsp_leap_year .. rsp_new_year      rsp_strobe, one cycle
//
// A transaction runs the wait, reduce, scan, sum, walk and emit steps in order:
// the reduce step subtracts 400 from the year until it is below 400, the scan
// visits all 12 months for day of year, and the walk crosses one month
// boundary per step until the remaining count fits the month. The walk loop
// sets the rate. Synchronous reset returns the sequencer to its wait step;
// there is no clearing pass. The receiver cannot stall, so the result is
// shown once.
// ---------------------------------------------------------------------------
module calendar_date_add_days #(
   parameter int MAX_ADD_DAYS = 65535
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_month_raw,
   input  logic [5:0]         req_day_raw,
   input  logic [13:0]        req_year_raw,
   input  logic [15:0]        req_days_to_add,
   output logic               rsp_strobe,
   output logic               rsp_leap_year,
   output logic [4:0]         rsp_month_length,
   output logic [8:0]         rsp_day_of_year,
   output logic signed [9:0]  rsp_days_left,
   output logic [3:0]         rsp_new_month,
   output logic [4:0]         rsp_new_day,
   output logic [13:0]        rsp_new_year
);
   import cdad_pkg::*;

`include "assert_macros.svh"

   // Remaining-days counter holds day of year plus the saturated count.
   localparam int TW = $clog2(MAX_ADD_DAYS + 367);

   ctrl_word_type ctrl;
   flags_type     flags;

   logic [3:0]    m_ff,      m_in;
   logic [4:0]    d_ff,      d_in;
   logic [3:0]    cm_ff,     cm_in;
   logic [13:0]   cy_ff,     cy_in;
   logic [13:0]   yr_ff,     yr_in;
   logic [8:0]    passed_ff, passed_in;
   logic [8:0]    after_ff,  after_in;
   logic [4:0]    mlen_ff,   mlen_in;
   logic [8:0]    doy_ff,    doy_in;
   logic [9:0]    left_ff,   left_in;
   logic          leap_ff,   leap_in;
   logic [TW-1:0] total_ff,  total_in;
   logic [4:0]    nd_ff,     nd_in;

   logic [4:0]    len_cur;
   logic [8:0]    doy_sum;
   logic          date_ok;

   cdad_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // Length of the month under the cursor, in the year under the cursor.
   assign len_cur = month_len(cm_ff, is_leap(yr_ff[8:0]));
   assign doy_sum = passed_ff + 9'(d_ff);

   // Flags for the sequencer's jumps.
   assign flags.start     = start;
   assign flags.year_high = (yr_ff >= 14'(YEAR_CYCLE));
   assign flags.scan_more = (cm_ff != 4'(MONTHS));
   assign flags.walk_more = (total_ff > TW'(len_cur));

   // Datapath next-state logic driven by the current control word.
   always_comb begin
      m_in      = m_ff;
      d_in      = d_ff;
      cm_in     = cm_ff;
      cy_in     = cy_ff;
      yr_in     = yr_ff;
      passed_in = passed_ff;
      after_in  = after_ff;
      mlen_in   = mlen_ff;
      doy_in    = doy_ff;
      left_in   = left_ff;
      leap_in   = leap_ff;
      total_in  = total_ff;
      nd_in     = nd_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            // Capture and normalize the request while waiting.
            m_in = (req_month_raw == 4'd0 || req_month_raw > 4'(MONTHS)) ?
                   4'd1 : req_month_raw;
            d_in = (req_day_raw == 6'd0 || req_day_raw > 6'(DAY_MAX)) ?
                   5'd1 : req_day_raw[4:0];
            cy_in = (req_year_raw < 14'(YEAR_BASE)) ? 14'(YEAR_BASE) : req_year_raw;
            yr_in = cy_in;
            if (32'(req_days_to_add) > 32'(MAX_ADD_DAYS)) begin
               total_in = TW'(MAX_ADD_DAYS);
            end else begin
               total_in = TW'(req_days_to_add);
            end
            cm_in     = 4'd1;
            passed_in = '0;
            after_in  = '0;
         end
         OP_REDUCE: begin
            // Bring the year into one 400-year cycle for the leap test.
            if (flags.year_high) begin
               yr_in = yr_ff - 14'(YEAR_CYCLE);
            end
         end
         OP_SCAN: begin
            // Sort each month's length into before, at or after the month.
            if (cm_ff < m_ff) begin
               passed_in = passed_ff + 9'(len_cur);
            end else if (cm_ff > m_ff) begin
               after_in = after_ff + 9'(len_cur);
            end else begin
               mlen_in = len_cur;
            end
            cm_in = flags.scan_more ? cm_ff + 4'd1 : 4'd1;
         end
         OP_SUM: begin
            // Year statistics and the starting point of the walk.
            doy_in   = doy_sum;
            left_in  = 10'(after_ff) + 10'(mlen_ff) - 10'(d_ff);
            leap_in  = is_leap(yr_ff[8:0]);
            total_in = total_ff + TW'(doy_sum);
         end
         OP_WALK: begin
            // Step one month forward, or settle on the day.
            if (flags.walk_more) begin
               total_in = total_ff - TW'(len_cur);
               if (cm_ff == 4'(MONTHS)) begin
                  cm_in = 4'd1;
                  cy_in = cy_ff + 14'd1;
                  yr_in = (yr_ff == 14'(YEAR_CYCLE - 1)) ? '0 : yr_ff + 14'd1;
               end else begin
                  cm_in = cm_ff + 4'd1;
               end
            end else begin
               nd_in = total_ff[4:0];
            end
         end
         OP_EMIT, OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // Datapath registers; payload only, so no reset.
   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      d_ff      <= d_in;
      cm_ff     <= cm_in;
      cy_ff     <= cy_in;
      yr_ff     <= yr_in;
      passed_ff <= passed_in;
      after_ff  <= after_in;
      mlen_ff   <= mlen_in;
      doy_ff    <= doy_in;
      left_ff   <= left_in;
      leap_ff   <= leap_in;
      total_ff  <= total_in;
      nd_ff     <= nd_in;
   end

   // Result transaction.
   assign rsp_strobe       = (ctrl.op == OP_EMIT);
   assign rsp_leap_year    = leap_ff;
   assign rsp_month_length = mlen_ff;
   assign rsp_day_of_year  = doy_ff;
   assign rsp_days_left    = $signed(left_ff);
   assign rsp_new_month    = cm_ff;
   assign rsp_new_day      = nd_ff;
   assign rsp_new_year     = cy_ff;

   // The reported date is always a real month and a nonzero day.
   assign date_ok = (rsp_new_month != 4'd0) && (rsp_new_month <= 4'(MONTHS)) &&
                    (rsp_new_day != 5'd0);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPL(a_emit_busy, clock, reset, rsp_strobe, busy)
   `ASSERT_NEXT(a_emit_release, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPL(a_date_valid, clock, reset, rsp_strobe, date_ok)

endmodule
